FILE: hw/rtl/hmsm_pkg.sv
// Shared types, constants and lookup tables for the Hu-moment shape matcher.
// No dependencies; imported by every module of the block.
package hmsm_pkg;

  localparam int unsigned MOMENT_W = 64;
  localparam int unsigned SIM_W    = 17;
  localparam int unsigned DIST_W   = 28;
  localparam int unsigned TERM_W   = 26;  // |log10 b - log10 a| in Q.16
  localparam int unsigned MANT_W   = 31;  // Q1.30 mantissa in the log unit
  localparam int unsigned FRAC_W   = 20;  // log2 fraction bits
  localparam int unsigned ZQ_W     = 21;  // d*d/2 in Q.16
  localparam int unsigned RQ_W     = 31;  // Q30 product, at most 1.0

  localparam logic [62:0]       EPS_BITS    = 63'h3EE4F8B588E368F1;
  localparam logic [DIST_W-1:0] DIST_MAX    = 28'hFFFFFFF;
  localparam logic [DIST_W-1:0] BELL_LIMIT  = 28'd327680;  // 5.0 in Q.16
  localparam logic [30:0]       LOG10_2_Q32 = 31'd1292913987;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic              nz_a;
    logic              nz_b;
    logic              scored;  // both magnitudes above the threshold
    logic [TERM_W-1:0] term;
  } pair_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQR,
    F_SCALE,
    F_ROUND,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_ACC,
    B_SQR,
    B_INIT,
    B_MUL,
    B_FIN
  } back_state_e;

  // exp(-k) in Q30
  function automatic logic [RQ_W-1:0] exp_int_q30(input logic [4:0] k);
    logic [RQ_W-1:0] v;
    case (k)
      5'd0:    v = 31'd1073741824;
      5'd1:    v = 31'd395007542;
      5'd2:    v = 31'd145315150;
      5'd3:    v = 31'd53458459;
      5'd4:    v = 31'd19666269;
      5'd5:    v = 31'd7234819;
      5'd6:    v = 31'd2661538;
      5'd7:    v = 31'd979126;
      5'd8:    v = 31'd360201;
      5'd9:    v = 31'd132510;
      5'd10:   v = 31'd48747;
      5'd11:   v = 31'd17933;
      5'd12:   v = 31'd6597;
      default: v = '0;
    endcase
    return v;
  endfunction

  // exp(-2^-(i+1)) in Q30
  function automatic logic [29:0] exp_frac_q30(input logic [3:0] i);
    logic [29:0] v;
    case (i)
      4'd0:    v = 30'd651257337;
      4'd1:    v = 30'd836230970;
      4'd2:    v = 30'd947573831;
      4'd3:    v = 30'd1008687093;
      4'd4:    v = 30'd1040706256;
      4'd5:    v = 30'd1057095003;
      4'd6:    v = 30'd1065385901;
      4'd7:    v = 30'd1069555702;
      4'd8:    v = 30'd1071646719;
      4'd9:    v = 30'd1072693760;
      4'd10:   v = 30'd1073217664;
      4'd11:   v = 30'd1073479712;
      4'd12:   v = 30'd1073610760;
      4'd13:   v = 30'd1073676290;
      4'd14:   v = 30'd1073709056;
      default: v = 30'd1073725440;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/hmsm_front.sv
// Front end: accepts moment pairs, applies the threshold and zero tests,
// and computes |log10 b - log10 a| with an iterative squaring log unit. Uses hmsm_pkg.
module hmsm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hmsm_pkg::MOMENT_W-1:0]  moment_a_i,
  input  logic [hmsm_pkg::MOMENT_W-1:0]  moment_b_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output hmsm_pkg::pair_t                push_data_o
);
  import hmsm_pkg::*;

  localparam logic [4:0] SQR_LAST = 5'(FRAC_W - 1);

  front_state_e state_q, state_d;
  logic [4:0]   step_q, step_d;

  logic [MANT_W-1:0] m_a_q, m_b_q;
  logic [FRAC_W-1:0] frac_a_q, frac_b_q;
  logic [10:0]       exp_a_q, exp_b_q;
  logic              sgn_a_q, sgn_b_q;
  logic              neg_a_q, neg_b_q;
  logic [61:0]       prod_a_q, prod_b_q;
  logic [TERM_W-1:0] r_a_q, r_b_q;
  logic              nz_a_q, nz_b_q, scored_q;

  logic        scored_in;
  logic [61:0] sq_prod_a, sq_prod_b;
  logic [31:0] sq_a, sq_b;
  logic [11:0] eu_a, eu_b;
  logic [31:0] l2_a, l2_b;
  logic [30:0] mag_a, mag_b;
  logic [61:0] scl_a, scl_b, rnd_a, rnd_b;
  logic [27:0] va, vb, diff;

  assign scored_in = (moment_a_i[62:0] > EPS_BITS) && (moment_b_i[62:0] > EPS_BITS);

  // one squaring per cycle; a product at 2.0 or above yields a 1 bit
  assign sq_prod_a = m_a_q * m_a_q;
  assign sq_prod_b = m_b_q * m_b_q;
  assign sq_a      = sq_prod_a[61:30];
  assign sq_b      = sq_prod_b[61:30];

  // log2 in Q.20: unbiased exponent above the fraction bits
  assign eu_a  = {1'b0, exp_a_q} - 12'd1023;
  assign eu_b  = {1'b0, exp_b_q} - 12'd1023;
  assign l2_a  = {eu_a, frac_a_q};
  assign l2_b  = {eu_b, frac_b_q};
  assign mag_a = l2_a[31] ? 31'(-l2_a) : l2_a[30:0];
  assign mag_b = l2_b[31] ? 31'(-l2_b) : l2_b[30:0];
  assign scl_a = mag_a * LOG10_2_Q32;
  assign scl_b = mag_b * LOG10_2_Q32;
  assign rnd_a = prod_a_q + (62'd1 << 35);
  assign rnd_b = prod_b_q + (62'd1 << 35);

  assign va   = neg_a_q ? 28'(-{2'b00, r_a_q}) : {2'b00, r_a_q};
  assign vb   = neg_b_q ? 28'(-{2'b00, r_b_q}) : {2'b00, r_b_q};
  assign diff = vb - va;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      F_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = scored_in ? F_SQR : F_PUSH;
        end
      end
      F_SQR: begin
        step_d = step_q + 5'd1;
        if (step_q == SQR_LAST) begin
          state_d = F_SCALE;
        end
      end
      F_SCALE: state_d = F_ROUND;
      F_ROUND: state_d = F_PUSH;
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = (state_q == F_IDLE);
    push_valid_o       = (state_q == F_PUSH);
    push_data_o.nz_a   = nz_a_q;
    push_data_o.nz_b   = nz_b_q;
    push_data_o.scored = scored_q;
    push_data_o.term   = diff[27] ? TERM_W'(-diff) : diff[TERM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          m_a_q    <= {1'b1, moment_a_i[51:22]};
          m_b_q    <= {1'b1, moment_b_i[51:22]};
          frac_a_q <= '0;
          frac_b_q <= '0;
          exp_a_q  <= moment_a_i[62:52];
          exp_b_q  <= moment_b_i[62:52];
          sgn_a_q  <= moment_a_i[63];
          sgn_b_q  <= moment_b_i[63];
          nz_a_q   <= |moment_a_i[62:0];
          nz_b_q   <= |moment_b_i[62:0];
          scored_q <= scored_in;
        end
      end
      F_SQR: begin
        m_a_q    <= sq_a[31] ? sq_a[31:1] : sq_a[30:0];
        m_b_q    <= sq_b[31] ? sq_b[31:1] : sq_b[30:0];
        frac_a_q <= {frac_a_q[FRAC_W-2:0], sq_a[31]};
        frac_b_q <= {frac_b_q[FRAC_W-2:0], sq_b[31]};
      end
      F_SCALE: begin
        prod_a_q <= scl_a;
        prod_b_q <= scl_b;
        neg_a_q  <= l2_a[31] ^ sgn_a_q;
        neg_b_q  <= l2_b[31] ^ sgn_b_q;
      end
      F_ROUND: begin
        r_a_q <= rnd_a[61:36];
        r_b_q <= rnd_b[61:36];
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/hmsm_queue.sv
// Two-entry queue of pairs, scored or not, between front and back end.
// Uses hmsm_pkg for the entry type.
module hmsm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hmsm_pkg::pair_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hmsm_pkg::pair_t pop_data_o
);
  import hmsm_pkg::*;

  pair_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/hmsm_back.sv
// Back end: saturating distance accumulator, pair counter and the
// sequential exp(-d^2/2) unit, with the output register. Uses hmsm_pkg.
module hmsm_back #(
  parameter int unsigned NUM_MOMENTS = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  hmsm_pkg::pair_t              pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hmsm_pkg::SIM_W-1:0]   similarity_o,
  output logic [hmsm_pkg::DIST_W-1:0]  distance_o,
  output logic                         set_mismatch_o
);
  import hmsm_pkg::*;

  localparam int unsigned IDX_W = (NUM_MOMENTS > 1) ? $clog2(NUM_MOMENTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MOMENTS - 1);

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q;
  logic [DIST_W-1:0] sum_q;
  logic              nz_a_q, nz_b_q;
  logic [3:0]        step_q;
  logic              out_valid_q;

  logic [DIST_W-1:0] dist_q;
  logic [ZQ_W-1:0]   z_q;
  logic [RQ_W-1:0]   r_q;
  logic [SIM_W-1:0]  out_sim_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_mism_q, mism_q;

  logic              do_pop, last, out_free;
  logic [DIST_W:0]   acc;
  logic [DIST_W-1:0] sum_new, dist_new;
  logic              nz_a_new, nz_b_new, mism_new;
  logic [37:0]       sqr_prod;
  logic [60:0]       mul_prod;
  logic [RQ_W-1:0]   rnd_r;
  logic [SIM_W-1:0]  sim_new;
  logic [15:0]       z_frac;

  assign do_pop   = pop_valid_i && pop_ready_o;
  assign last     = (idx_q == LAST_IDX);
  assign out_free = !out_valid_q || out_ready_i;

  assign acc      = {1'b0, sum_q} + {3'b000, pop_data_i.term};
  assign sum_new  = !pop_data_i.scored ? sum_q :
                    (acc > {1'b0, DIST_MAX}) ? DIST_MAX : acc[DIST_W-1:0];
  assign nz_a_new = nz_a_q | pop_data_i.nz_a;
  assign nz_b_new = nz_b_q | pop_data_i.nz_b;
  assign mism_new = nz_a_new != nz_b_new;
  assign dist_new = mism_new ? DIST_MAX : sum_new;

  // bell curve datapath: d*d/2, then one Q30 product per fraction bit
  assign sqr_prod = dist_q[18:0] * dist_q[18:0];
  assign z_frac   = z_q[15:0];
  assign mul_prod = (r_q * exp_frac_q30(step_q)) + (61'd1 << 29);
  assign rnd_r    = r_q + (31'd1 << 13);
  assign sim_new  = (rnd_r[RQ_W-1:14] > 17'd65536) ? 17'd65536 : rnd_r[RQ_W-1:14];

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_ACC: begin
        if (do_pop && last) begin
          state_d = (mism_new || dist_new >= BELL_LIMIT) ? B_FIN : B_SQR;
        end
      end
      B_SQR:  state_d = B_INIT;
      B_INIT: state_d = B_MUL;
      B_MUL: begin
        if (step_q == 4'd15) begin
          state_d = B_FIN;
        end
      end
      B_FIN: begin
        if (out_free) begin
          state_d = B_ACC;
        end
      end
      default: state_d = B_ACC;
    endcase
  end

  always_comb begin
    pop_ready_o    = (state_q == B_ACC);
    out_valid_o    = out_valid_q;
    similarity_o   = out_sim_q;
    distance_o     = out_dist_q;
    set_mismatch_o = out_mism_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_ACC;
      idx_q       <= '0;
      sum_q       <= '0;
      nz_a_q      <= 1'b0;
      nz_b_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_pop) begin
        if (last) begin
          idx_q  <= '0;
          sum_q  <= '0;
          nz_a_q <= 1'b0;
          nz_b_q <= 1'b0;
        end else begin
          idx_q  <= idx_q + 1'b1;
          sum_q  <= sum_new;
          nz_a_q <= nz_a_new;
          nz_b_q <= nz_b_new;
        end
      end
      if (state_q == B_INIT) begin
        step_q <= '0;
      end else if (state_q == B_MUL) begin
        step_q <= step_q + 4'd1;
      end
      if (state_q == B_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_ACC: begin
        if (do_pop && last) begin
          dist_q <= dist_new;
          mism_q <= mism_new;
          r_q    <= '0;  // similarity 0 unless the bell unit runs
        end
      end
      B_SQR:  z_q <= sqr_prod[37:17];
      B_INIT: r_q <= exp_int_q30(z_q[20:16]);
      B_MUL: begin
        if (z_frac[4'd15 - step_q]) begin
          r_q <= mul_prod[60:30];
        end
      end
      B_FIN: begin
        if (out_free) begin
          out_sim_q  <= sim_new;
          out_dist_q <= dist_q;
          out_mism_q <= mism_q;
        end
      end
      default: ;
    endcase
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX)
    else $error("pair counter past the last moment");

  a_mismatch_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mism_q |-> out_dist_q == DIST_MAX && out_sim_q == '0)
    else $error("set mismatch without forced distance and zero similarity");

  a_far_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sim_q != '0 |-> out_dist_q < BELL_LIMIT)
    else $error("nonzero similarity for a distance of 5.0 or more");

  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_MUL |=> state_q == B_MUL || state_q == B_FIN)
    else $error("bell unit left its product loop early");

endmodule

FILE: hw/rtl/hu_moment_shape_match.sv
// Top level of the Hu-moment shape matcher: stream ports, front end, queue
// and back end. Depends on hmsm_pkg, hmsm_front, hmsm_queue, hmsm_back.
//
//  channel   dir  tdata bits (low to high)                          tuser/tlast
//  s_axis    in   moment_a[63:0], moment_b[127:64]                   none
//  m_axis    out  similarity[16:0], distance[44:17],                 none
//                 set_mismatch[45], zero[47:46]
//
// A pair whose magnitudes both exceed 1e-5 passes the front end through
// accept, 20 squaring steps of the log unit, scale, round and push; any
// other pair goes from accept straight to push. The log unit sets the rate.
// After the last pair of a match under 5.0 without set mismatch, the back end
// works out the similarity (square, table load, 16 Q30 products, output load);
// meanwhile the front end keeps scoring pairs of the next match into the queue.
// Reset is asynchronous and active low; all control state and the running
// match return to their cleared values, with no clearing pass.
// The output register holds a result while m_axis_tready_i is low; the
// back end stalls only when a second result is ready before the first
// word has left, and the front end only when the queue is full.
module hu_moment_shape_match #(
  parameter int unsigned NUM_MOMENTS = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [127:0]  s_axis_tdata_i,   // moment_a[63:0], moment_b[127:64]
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [47:0]   m_axis_tdata_o    // similarity[16:0], distance[44:17],
                                          // set_mismatch[45], zero pad [47:46]
);
  import hmsm_pkg::*;

  // front to queue
  logic  push_valid, push_ready;
  pair_t push_data;
  // queue to back
  logic  pop_valid, pop_ready;
  pair_t pop_data;

  logic [SIM_W-1:0]  similarity;
  logic [DIST_W-1:0] distance;
  logic              set_mismatch;

  hmsm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .moment_a_i   (s_axis_tdata_i[63:0]),
    .moment_b_i   (s_axis_tdata_i[127:64]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples per-pair scoring from accumulation and the bell unit
  hmsm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  hmsm_back #(
    .NUM_MOMENTS (NUM_MOMENTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .similarity_o   (similarity),
    .distance_o     (distance),
    .set_mismatch_o (set_mismatch)
  );

  // result word, first field in the low bits
  assign m_axis_tdata_o = {2'b00, set_mismatch, distance, similarity};

endmodule

FILE: test/hmsm_match_checker.sv
`timescale 1ns / 1ps
// Result checker for the Hu-moment shape matcher: watches both stream channels,
// predicts each match result and compares it with the output words. Needs no package.
module hmsm_match_checker #(
  parameter int unsigned NUM_PAIRS = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [127:0] s_axis_tdata_i,   // moment_a[63:0], moment_b[127:64]
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [47:0]  m_axis_tdata_i,   // similarity[16:0], distance[44:17],
                                         // set_mismatch[45], pad[47:46]
  output int unsigned  mismatch_count_o,
  output int unsigned  outstanding_o
);

  localparam logic [62:0] SCORE_FLOOR = 63'h3EE4F8B588E368F1;  // |x| > 1e-5
  localparam logic [27:0] DIST_SAT    = 28'h0FFFFFFF;
  localparam logic [27:0] BELL_CUTOFF = 28'd327680;              // 5.0 in Q.16

  // packed from the top bit down: similarity lands in the low bits
  typedef struct packed {
    logic        mism;
    logic [27:0] distance;
    logic [16:0] sim;
  } match_res_t;

  match_res_t  match_q[$];
  int unsigned errors    = 0;
  int unsigned pending_n = 0;

  int unsigned pairs_seen;
  logic [27:0] dist_acc;
  logic        seen_a, seen_b;

  assign mismatch_count_o = errors;
  assign outstanding_o    = pending_n;

  // exp(-k), Q30
  function automatic longint unsigned exp_whole_q30(input int k);
    case (k)
      0:       return 64'd1073741824;
      1:       return 64'd395007542;
      2:       return 64'd145315150;
      3:       return 64'd53458459;
      4:       return 64'd19666269;
      5:       return 64'd7234819;
      6:       return 64'd2661538;
      7:       return 64'd979126;
      8:       return 64'd360201;
      9:       return 64'd132510;
      10:      return 64'd48747;
      11:      return 64'd17933;
      default: return 64'd6597;
    endcase
  endfunction

  // exp(-2^-(i+1)), Q30
  function automatic longint unsigned exp_bit_q30(input int i);
    case (i)
      0:       return 64'd651257337;
      1:       return 64'd836230970;
      2:       return 64'd947573831;
      3:       return 64'd1008687093;
      4:       return 64'd1040706256;
      5:       return 64'd1057095003;
      6:       return 64'd1065385901;
      7:       return 64'd1069555702;
      8:       return 64'd1071646719;
      9:       return 64'd1072693760;
      10:      return 64'd1073217664;
      11:      return 64'd1073479712;
      12:      return 64'd1073610760;
      13:      return 64'd1073676290;
      14:      return 64'd1073709056;
      default: return 64'd1073725440;
    endcase
  endfunction

  // Signed log10 of |x| in Q.16; log2 via mantissa squaring, then scaled.
  function automatic longint log10_mag_q16(input logic [63:0] x);
    longint unsigned mant, frac, mag, r;
    longint          l2;
    int              i;
    mant = (64'd1 << 30) | longint'(x[51:22]);
    frac = 0;
    for (i = 0; i < 20; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        frac = frac | 64'd1;
        mant = mant >> 1;
      end
    end
    l2  = (longint'(x[62:52]) - 1023) * 1048576 + longint'(frac);
    mag = (l2 < 0) ? longint'(-l2) : l2;
    r   = (mag * 64'd1292913987 + (64'd1 << 35)) >> 36;
    return (l2 < 0) ? -longint'(r) : longint'(r);
  endfunction

  // exp(-d*d/2) in Q1.16
  function automatic logic [16:0] similarity_q16(input logic [27:0] d);
    longint unsigned z, r;
    int              k, i;
    if (d >= BELL_CUTOFF) return '0;
    z = (longint'(d) * longint'(d)) >> 17;
    k = int'(z >> 16);
    if (k > 12) return '0;
    r = exp_whole_q30(k);
    for (i = 0; i < 16; i++) begin
      if (z[15-i])
        r = (r * exp_bit_q30(i) + (64'd1 << 29)) >> 30;
    end
    r = (r + (64'd1 << 13)) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0]     mom_a, mom_b;
    longint          va, vb, diff;
    longint unsigned sum;
    match_res_t      want, got;
    if (!rst_ni) begin
      pairs_seen = 0;
      dist_acc   = '0;
      seen_a     = 1'b0;
      seen_b     = 1'b0;
    end else begin
      // output side first: a result can never leave in the cycle it is predicted
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[45:0];
        if (match_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: result word with no match pending: %h", $realtime,
                     m_axis_tdata_i);
          errors++;
        end else begin
          want = match_q.pop_front();
          if (got.sim !== want.sim || got.distance !== want.distance ||
              got.mism !== want.mism || m_axis_tdata_i[47:46] !== 2'b00) begin
            if (errors < 10)
              $display("%0t: similarity %0d/%0d distance %h/%h mismatch %b/%b pad %b",
                       $realtime, want.sim, got.sim, want.distance, got.distance,
                       want.mism, got.mism, m_axis_tdata_i[47:46]);
            errors++;
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        mom_a = s_axis_tdata_i[63:0];
        mom_b = s_axis_tdata_i[127:64];
        if (mom_a[62:0] != '0) seen_a = 1'b1;   // negative zero is zero
        if (mom_b[62:0] != '0) seen_b = 1'b1;
        if (mom_a[62:0] > SCORE_FLOOR && mom_b[62:0] > SCORE_FLOOR) begin
          va   = mom_a[63] ? -log10_mag_q16(mom_a) : log10_mag_q16(mom_a);
          vb   = mom_b[63] ? -log10_mag_q16(mom_b) : log10_mag_q16(mom_b);
          diff = vb - va;
          sum  = longint'(dist_acc) + ((diff < 0) ? -diff : diff);
          dist_acc = (sum > longint'(DIST_SAT)) ? DIST_SAT : sum[27:0];
        end
        pairs_seen++;
        if (pairs_seen == NUM_PAIRS) begin
          want.mism     = seen_a ^ seen_b;
          want.distance = want.mism ? DIST_SAT : dist_acc;
          want.sim      = want.mism ? 17'd0 : similarity_q16(want.distance);
          match_q.push_back(want);
          pairs_seen = 0;
          dist_acc   = '0;
          seen_a     = 1'b0;
          seen_b     = 1'b0;
        end
      end
    end
    pending_n = match_q.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the Hu-moment shape matcher; checking is done by
// hmsm_match_checker. Depends on hu_moment_shape_match and its package.
module tb_top;

  localparam int unsigned NUM_PAIRS     = 7;
  localparam int unsigned RANDOM_PAIRS  = 1000;
  localparam logic [62:0] SCORE_FLOOR   = 63'h3EE4F8B588E368F1;  // pattern of 1e-5
  localparam logic [63:0] NEG_ZERO      = 64'h8000000000000000;
  localparam logic [63:0] ONE_POS       = 64'h3FF0000000000000;
  localparam logic [63:0] ONE_NEG       = 64'hBFF0000000000000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;    // moment_a[63:0], moment_b[127:64]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;    // similarity[16:0], distance[44:17],
                                 // set_mismatch[45], pad[47:46]

  int unsigned  mismatch_count;
  int unsigned  outstanding;

  // one match worth of moments, filled before send_shapes
  logic [63:0]  shape_a [NUM_PAIRS];
  logic [63:0]  shape_b [NUM_PAIRS];
  int unsigned  words_sent = 0;
  bit           steady     = 1'b0;   // no new idle gaps on either side while set
  int           stall_left = 0;

  hu_moment_shape_match #(
    .NUM_MOMENTS(NUM_PAIRS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  hmsm_match_checker #(
    .NUM_PAIRS(NUM_PAIRS)
  ) match_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("[hu_moment_shape_match] ERROR");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [51:0] rand_mant();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[51:0];
  endfunction

  // Typical Hu moment magnitude (2^-47 up to just under 2), sometimes any normal exponent.
  function automatic logic [63:0] hu_like();
    logic [10:0] ex;
    if ($urandom_range(0, 9) == 0) ex = 11'($urandom_range(1, 2046));
    else                           ex = 11'($urandom_range(12'h3D0, 12'h3FF));
    return {1'($urandom), ex, rand_mant()};
  endfunction

  // Zero, negative zero, or something under the threshold.
  function automatic logic [63:0] quiet_moment();
    case ($urandom_range(0, 3))
      0:       return 64'd0;
      1:       return NEG_ZERO;
      default: return {1'($urandom), 11'($urandom_range(0, 12'h3ED)), rand_mant()};
    endcase
  endfunction

  // Threshold edges, denormals, inf/NaN patterns, extremes.
  function automatic logic [63:0] edge_moment();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return NEG_ZERO;
      2:       return {1'($urandom), SCORE_FLOOR};
      3:       return {1'($urandom), SCORE_FLOOR + 63'd1};
      4:       return {1'($urandom), SCORE_FLOOR - 63'd1};
      5:       return {1'($urandom), 11'h7FF, rand_mant()};
      6:       return {1'($urandom), 11'h000, rand_mant()};
      7:       return {$urandom, $urandom};
      8:       return {1'($urandom), 63'h7FEFFFFFFFFFFFFF};
      default: return hu_like();
    endcase
  endfunction

  task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
    int idle;
    idle = steady ? 0 : gap_len();
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tdata  <= {b, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_shapes();
    int j;
    for (j = 0; j < NUM_PAIRS; j++) send_pair(shape_a[j], shape_b[j]);
  endtask

  // Hold the sender until every match result has left the block.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls unless a steady stretch is running.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 7) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin
    int j, r, waited;
    bit side;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Field extremes, threshold edges, zero and negative zero, inf/NaN codes.
    shape_a = '{64'd0, NEG_ZERO, {1'b0, SCORE_FLOOR}, {1'b0, SCORE_FLOOR + 63'd1},
                64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001, ONE_NEG};
    shape_b = '{64'd0, ONE_POS, {1'b0, SCORE_FLOOR + 63'd1},
                {1'b1, SCORE_FLOOR + 63'd1}, 64'h7FF0000000000000,
                64'h3FE0000000000000, ONE_POS};
    send_shapes();
    // Largest opposite-sign logs every pair: the sum saturates.
    for (j = 0; j < NUM_PAIRS; j++) begin
      shape_a[j] = 64'hFFFFFFFFFFFFFFFF;
      shape_b[j] = 64'h7FFFFFFFFFFFFFFF;
    end
    send_shapes();
    // Only set B has a nonzero moment: set mismatch.
    for (j = 0; j < NUM_PAIRS; j++) begin
      shape_a[j] = j[0] ? NEG_ZERO : 64'd0;
      shape_b[j] = hu_like();
    end
    send_shapes();
    // Identical shapes: distance 0, similarity exactly one.
    for (j = 0; j < NUM_PAIRS; j++) begin
      shape_a[j] = hu_like();
      shape_b[j] = shape_a[j];
    end
    send_shapes();
    drain();

    // Random matches; every pair counts, so every sequence is well formed.
    while (words_sent < 4 * NUM_PAIRS + RANDOM_PAIRS) begin
      steady = ($urandom_range(0, 3) == 0);
      r      = $urandom_range(0, 99);
      side   = 1'($urandom);
      for (j = 0; j < NUM_PAIRS; j++) begin
        if (r < 35) begin
          // near-identical: small mantissa change, sometimes one octave off
          shape_a[j] = hu_like();
          shape_b[j] = shape_a[j];
          shape_b[j][51:0] = shape_b[j][51:0] ^ (rand_mant() >> $urandom_range(0, 52));
          if ($urandom_range(0, 7) == 0) shape_b[j][52] = ~shape_b[j][52];
        end else if (r < 55) begin
          shape_a[j] = hu_like();
          shape_b[j] = hu_like();
        end else if (r < 65) begin
          shape_a[j] = {$urandom, $urandom};
          shape_b[j] = {$urandom, $urandom};
        end else if (r < 80) begin
          shape_a[j] = edge_moment();
          shape_b[j] = edge_moment();
        end else if (r < 90) begin
          // one set all zeros, the other set nonzero
          shape_a[j] = side ? ($urandom_range(0, 1) ? 64'd0 : NEG_ZERO) : hu_like();
          shape_b[j] = side ? hu_like() : ($urandom_range(0, 1) ? 64'd0 : NEG_ZERO);
        end else begin
          shape_a[j] = quiet_moment();
          shape_b[j] = quiet_moment();
        end
      end
      send_shapes();
      if (words_sent >= 4 * NUM_PAIRS + RANDOM_PAIRS / 2 &&
          words_sent < 4 * NUM_PAIRS + RANDOM_PAIRS / 2 + NUM_PAIRS)
        drain();
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    waited = 0;
    while (outstanding != 0 && waited < 200000) begin
      @(negedge clk_i);
      waited++;
    end
    // margin for anything still in the front end and back end
    repeat (80) @(negedge clk_i);

    if (mismatch_count == 0 && outstanding == 0)
      $display("[hu_moment_shape_match] OK");
    else
      $display("[hu_moment_shape_match] ERROR");
    $finish;
  end

endmodule
